// ===== rtl/core/lgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the largest gap steering core
// Register indexes, sequencer states, field widths and reset defaults.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int MAX_SAMPLES = 2048;
	localparam int IDX_W       = 11;
	localparam int LEN_W       = 12;
	localparam int CENTRE_W    = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 56;

	localparam logic [IDX_W-1:0] IDX_CAP =
		(MAX_SAMPLES > 2048) ? IDX_W'(2047) : IDX_W'(MAX_SAMPLES - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [15:0] NEAR_RST  = 16'd500;
	localparam logic [15:0] FAR_RST   = 16'd1500;
	localparam logic [11:0] MINGAP_RST = 12'd120;
	localparam logic [9:0]  STEP_RST  = 10'd64;
	localparam logic [14:0] FWD_RST   = 15'd5760;
	localparam logic [15:0] GAIN_RST  = 16'd10486;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR_LIMIT = 3'd0,
		REG_FAR_LIMIT  = 3'd1,
		REG_MIN_GAP    = 3'd2,
		REG_ANGLE_STEP = 3'd3,
		REG_FWD_ANGLE  = 3'd4,
		REG_STEER_GAIN = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_START,
		ST_MUL_LEN,
		ST_CENTRE,
		ST_MUL_STEER,
		ST_RESULT
	} lgs_state_t;

endpackage

// ===== rtl/core/largest_gap_steering_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_gap_steering_core: follow-the-gap steering over a lidar scan
// Classifies range samples, tracks the longest free run and, at the end of a
// scan, computes the gap centre and a saturated steering command.
// ----------------------------------------------------------------------------
// Channel   | Dir | Signals                                 | Beat
// s_axis    | in  | tvalid tready tdata[15:0] tlast         | one range sample
// m_axis    | out | tvalid tready tdata[55:0]               | one scan result
// cfg       | in  | cfg_we cfg_index[2:0] cfg_wdata[15:0]   | one register write
//
// An ordinary sample leaves the sequencer idle, so s_axis_tready stays high.
// A sample with tlast runs the sequencer, which uses one shared 17x17 signed
// multiplier three times (start, length, steering) before the result step.
// The result beat waits in an output register; a stalled m_axis holds the
// sequencer in its final step and keeps s_axis_tready low.
// arst_n clears all scan state and loads register defaults.
// ----------------------------------------------------------------------------
module largest_gap_steering_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [lgs_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] range_mm
	input  logic                          s_axis_tlast,  // last_sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] steering, [30:16] centre_angle, [41:31] gap_start,
	// [53:42] gap_length, [54] gap_found, [55] zero
	output logic [lgs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import lgs_pkg::*;

	logic [15:0] near_q, far_q, gain_q;
	logic [11:0] min_gap_q;
	logic [9:0]  step_q;
	logic [14:0] fwd_q;

	logic [IDX_W-1:0]    sample_index_q, run_start_q, best_start_q;
	logic [LEN_W-1:0]    run_length_q, best_length_q;
	logic                run_open_q, best_found_q;
	logic [CENTRE_W-1:0] held_centre_q;

	lgs_state_t state_q, state_d;

	logic signed [33:0] prod_q;
	logic [20:0]        acc_q;
	logic signed [16:0] mul_a, mul_b;
	logic               mul_en;
	logic               result_go;

	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q    <= NEAR_RST;
			far_q     <= FAR_RST;
			min_gap_q <= MINGAP_RST;
			step_q    <= STEP_RST;
			fwd_q     <= FWD_RST;
			gain_q    <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR_LIMIT: near_q    <= cfg_wdata;
				REG_FAR_LIMIT:  far_q     <= cfg_wdata;
				REG_MIN_GAP:    min_gap_q <= cfg_wdata[11:0];
				REG_ANGLE_STEP: step_q    <= cfg_wdata[9:0];
				REG_FWD_ANGLE:  fwd_q     <= cfg_wdata[14:0];
				REG_STEER_GAIN: gain_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- per-sample classification ----------------
	logic              in_beat, obstacle, open_now, close_now, beat_best;
	logic [LEN_W-1:0]  len_base, len_next, bar;
	logic [IDX_W-1:0]  start_next;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	always_comb begin
		obstacle   = (sample_index_q == '0) || s_axis_tlast ||
		             ((s_axis_tdata > near_q) && (s_axis_tdata < far_q));
		open_now   = run_open_q || !obstacle;
		len_base   = run_open_q ? run_length_q : '0;
		start_next = run_open_q ? run_start_q : sample_index_q;
		len_next   = (open_now && (len_base < LEN_MAX)) ? len_base + LEN_W'(1) : len_base;
		close_now  = obstacle && run_open_q;
		bar        = best_found_q ? best_length_q : min_gap_q;
		beat_best  = close_now && (len_next > bar);
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_beat && s_axis_tlast) state_d = ST_MUL_START;
			ST_MUL_START: state_d = ST_MUL_LEN;
			ST_MUL_LEN:   state_d = ST_CENTRE;
			ST_CENTRE:    state_d = ST_MUL_STEER;
			ST_MUL_STEER: state_d = ST_RESULT;
			ST_RESULT:    if (result_go) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_en    = 1'b0;
		result_go = 1'b0;
		unique case (state_q)
			ST_MUL_START: begin
				mul_a  = 17'(best_start_q);
				mul_b  = 17'(step_q);
				mul_en = 1'b1;
			end
			ST_MUL_LEN: begin
				mul_a  = 17'(best_length_q);
				mul_b  = 17'(step_q);
				mul_en = 1'b1;
			end
			ST_MUL_STEER: begin
				mul_a  = 17'(gain_q);
				mul_b  = $signed({2'b00, held_centre_q}) - $signed({2'b00, fwd_q});
				mul_en = 1'b1;
			end
			ST_RESULT: result_go = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_a * mul_b;
		if (state_q == ST_MUL_LEN) acc_q <= prod_q[20:0];
	end

	// centre: start*step + floor(length*step/2), saturated
	logic [21:0] centre_sum;
	assign centre_sum = {1'b0, acc_q} + {1'b0, prod_q[21:1]};

	// steering: floor(product / 65536), saturated to 16 bits signed
	logic signed [17:0] steer_full;
	logic        [15:0] steer_sat;
	always_comb begin
		steer_full = prod_q[33:16];
		if (steer_full > 18'sd32767)       steer_sat = 16'h7FFF;
		else if (steer_full < -18'sd32768) steer_sat = 16'h8000;
		else                               steer_sat = steer_full[15:0];
	end

	// ---------------- scan state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			run_open_q     <= 1'b0;
			run_start_q    <= '0;
			run_length_q   <= '0;
			best_start_q   <= '0;
			best_length_q  <= '0;
			best_found_q   <= 1'b0;
			held_centre_q  <= '0;
		end else begin
			if (in_beat) begin
				if (close_now) begin
					run_open_q   <= 1'b0;
					run_start_q  <= '0;
					run_length_q <= '0;
				end else begin
					run_open_q   <= open_now;
					run_start_q  <= open_now ? start_next : '0;
					run_length_q <= len_next;
				end
				if (beat_best) begin
					best_start_q  <= start_next;
					best_length_q <= len_next;
					best_found_q  <= 1'b1;
				end
				if (!s_axis_tlast && (sample_index_q < IDX_CAP))
					sample_index_q <= sample_index_q + IDX_W'(1);
			end
			if ((state_q == ST_CENTRE) && best_found_q)
				held_centre_q <= (centre_sum > 22'd32767) ? 15'h7FFF : centre_sum[14:0];
			// drop the scan once its result beat is loaded
			if (result_go) begin
				sample_index_q <= '0;
				run_open_q     <= 1'b0;
				run_start_q    <= '0;
				run_length_q   <= '0;
				best_start_q   <= '0;
				best_length_q  <= '0;
				best_found_q   <= 1'b0;
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                         out_valid_q <= 1'b0;
		else if (result_go)                  out_valid_q <= 1'b1;
		else if (m_axis_tready)              out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (result_go)
			out_data_q <= {1'b0,
			               best_found_q,
			               best_found_q ? best_length_q : {LEN_W{1'b0}},
			               best_found_q ? best_start_q : {IDX_W{1'b0}},
			               held_centre_q,
			               steer_sat};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- assertions ----------------
	a_run_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run_open_q |-> (run_length_q == '0) && (run_start_q == '0))
		else $error("closed run holds a length or start");

	a_best_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		!best_found_q |-> (best_length_q == '0))
		else $error("best length set without a found gap");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_axis_tlast) |=> !s_axis_tready && !m_axis_tvalid || !s_axis_tready)
		else $error("input accepted during end-of-scan sequence");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		result_go |=> (sample_index_q == '0) && !best_found_q && m_axis_tvalid)
		else $error("scan state not cleared after result");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for largest_gap_steering_core
// Streams lidar scans into the core, predicts each end-of-scan result from a
// behavioral model of the gap search and steering math, and compares every
// result beat field by field. Registers are rewritten between scan batches
// while the core is idle; both stream sides insert random idle bursts.
// ----------------------------------------------------------------------------
module testbench;
	import lgs_pkg::*;

	typedef struct {
		logic [15:0] range_mm;
		logic        last;
	} sample_t;

	// m_axis_tdata layout, lowest field last
	typedef struct packed {
		logic        spare;
		logic        gap_found;
		logic [11:0] gap_length;
		logic [10:0] gap_start;
		logic [14:0] centre_angle;
		logic [15:0] steering;
	} scan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_NEAR_LIMIT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [15:0] range_mm
	logic                  s_axis_tlast = 1'b0; // last_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [15:0] steering, [30:16] centre_angle, [41:31] gap_start,
	// [53:42] gap_length, [54] gap_found, [55] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	largest_gap_steering_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	sample_t      sample_q[$];
	scan_result_t scan_result_q[$];
	int           err_count = 0;
	logic         idle_en = 1'b1;

	// mirrored registers
	logic [15:0] near_mm, far_mm, gain;
	logic [11:0] min_gap;
	logic [9:0]  ang_step;
	logic [14:0] fwd_ang;

	// per-scan search state
	logic [10:0] scan_idx, run_st, best_st;
	logic [11:0] run_len, best_len;
	logic        run_on, best_ok;
	logic [14:0] held_centre;

	task automatic reset_gap_search();
		near_mm = NEAR_RST;
		far_mm = FAR_RST;
		min_gap = MINGAP_RST;
		ang_step = STEP_RST;
		fwd_ang = FWD_RST;
		gain = GAIN_RST;
		held_centre = '0;
		scan_idx = '0;
		run_on = 1'b0;
		run_st = '0;
		run_len = '0;
		best_st = '0;
		best_len = '0;
		best_ok = 1'b0;
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		case (cfg_reg_t'(idx))
			REG_NEAR_LIMIT: near_mm = val;
			REG_FAR_LIMIT:  far_mm = val;
			REG_MIN_GAP:    min_gap = val[11:0];
			REG_ANGLE_STEP: ang_step = val[9:0];
			REG_FWD_ANGLE:  fwd_ang = val[14:0];
			REG_STEER_GAIN: gain = val;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] steer_cmd(input logic [14:0] centre,
			input logic [14:0] fwd, input logic [15:0] g);
		longint c_l, f_l, g_l, p;
		c_l = centre;
		f_l = fwd;
		g_l = g;
		p = (g_l * (c_l - f_l)) >>> 16;
		if (p > 32767)
			p = 32767;
		if (p < -32768)
			p = -32768;
		return p[15:0];
	endfunction

	task automatic track_gap(input logic [15:0] r, input logic lst);
		logic         obst;
		logic [11:0]  bar;
		logic [31:0]  c;
		scan_result_t res;
		obst = (scan_idx == 0) || lst || (r > near_mm && r < far_mm);
		if (!obst && !run_on) begin
			run_on = 1'b1;
			run_st = scan_idx;
			run_len = '0;
		end
		if (run_on && run_len != LEN_MAX)
			run_len = run_len + 1'b1;
		if (obst && run_on) begin
			bar = best_ok ? best_len : min_gap;
			if (run_len > bar) begin
				best_st = run_st;
				best_len = run_len;
				best_ok = 1'b1;
			end
			run_on = 1'b0;
			run_st = '0;
			run_len = '0;
		end
		if (!lst) begin
			if (scan_idx < IDX_CAP)
				scan_idx = scan_idx + 1'b1;
		end else begin
			if (best_ok) begin
				c = best_st * ang_step + (best_len * ang_step) / 2;
				held_centre = (c > 32767) ? 15'h7FFF : c[14:0];
			end
			res.spare = 1'b0;
			res.gap_found = best_ok;
			res.gap_length = best_ok ? best_len : '0;
			res.gap_start = best_ok ? best_st : '0;
			res.centre_angle = held_centre;
			res.steering = steer_cmd(held_centre, fwd_ang, gain);
			scan_result_q.push_back(res);
			scan_idx = '0;
			run_on = 1'b0;
			run_st = '0;
			run_len = '0;
			best_st = '0;
			best_len = '0;
			best_ok = 1'b0;
		end
	endtask

	task automatic check_result(input scan_result_t got);
		scan_result_t want;
		if (scan_result_q.size() == 0) begin
			$error("unexpected scan result beat %h", got);
			err_count++;
			return;
		end
		want = scan_result_q.pop_front();
		if (got.steering !== want.steering) begin
			$error("steering: expected %0d, got %0d", $signed(want.steering),
				$signed(got.steering));
			err_count++;
		end
		if (got.centre_angle !== want.centre_angle) begin
			$error("centre_angle: expected %0d, got %0d", want.centre_angle,
				got.centre_angle);
			err_count++;
		end
		if (got.gap_start !== want.gap_start) begin
			$error("gap_start: expected %0d, got %0d", want.gap_start, got.gap_start);
			err_count++;
		end
		if (got.gap_length !== want.gap_length) begin
			$error("gap_length: expected %0d, got %0d", want.gap_length, got.gap_length);
			err_count++;
		end
		if (got.gap_found !== want.gap_found) begin
			$error("gap_found: expected %0d, got %0d", want.gap_found, got.gap_found);
			err_count++;
		end
	endtask

	// Model and monitor: everything sampled at the rising edge
	logic beat_taken = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_gap_search();
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= s_axis_tvalid && s_axis_tready;
			if (cfg_we)
				apply_write(cfg_index, cfg_wdata);
			if (s_axis_tvalid && s_axis_tready)
				track_gap(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_result(scan_result_t'(m_axis_tdata));
		end
	end

	// Sample driver
	int unsigned in_hold = 0;
	sample_t     next_beat;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || beat_taken) begin
			if (in_hold != 0) begin
				s_axis_tvalid <= 1'b0;
				in_hold <= in_hold - 1;
			end else if (sample_q.size() != 0) begin
				next_beat = sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_beat.range_mm;
				s_axis_tlast <= next_beat.last;
				if (idle_en && $urandom_range(0, 5) == 0)
					in_hold <= $urandom_range(1, 15);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result sink with random stall bursts
	int unsigned out_hold = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (out_hold != 0) begin
			m_axis_tready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (idle_en && $urandom_range(0, 7) == 0)
				out_hold <= $urandom_range(1, 15);
		end
	end

	task automatic push_sample(input logic [15:0] r, input logic lst);
		sample_t s;
		s.range_mm = r;
		s.last = lst;
		sample_q.push_back(s);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait out every queued beat and result, then the sequencer latency
	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || scan_result_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_range(input logic want_free);
		if ($urandom_range(0, 15) == 0)
			return 16'($urandom);
		if (want_free) begin
			if ($urandom_range(0, 1))
				return 16'($urandom_range(0, near_mm));
			return 16'($urandom_range(far_mm, 16'hFFFF));
		end
		if (far_mm > near_mm + 1)
			return 16'($urandom_range(near_mm + 1, far_mm - 1));
		return 16'($urandom);
	endfunction

	// Alternate obstacle and free stretches; the final sample closes the scan
	task automatic add_scan(input int len);
		logic free_now;
		int   left;
		free_now = 1'b1;
		left = 0;
		for (int i = 0; i < len; i++) begin
			if (left == 0) begin
				free_now = !free_now;
				if (!free_now)
					left = $urandom_range(1, 6);
				else if ($urandom_range(0, 3) == 0)
					left = $urandom_range(1, 80);
				else
					left = $urandom_range(1, 12);
			end
			push_sample(pick_range(free_now), i == len - 1);
			left--;
		end
	endtask

	task automatic write_all(input logic [15:0] nr, input logic [15:0] fr,
			input logic [15:0] mg, input logic [15:0] st,
			input logic [15:0] fw, input logic [15:0] gn);
		write_reg(REG_NEAR_LIMIT, nr);
		write_reg(REG_FAR_LIMIT, fr);
		write_reg(REG_MIN_GAP, mg);
		write_reg(REG_ANGLE_STEP, st);
		write_reg(REG_FWD_ANGLE, fw);
		write_reg(REG_STEER_GAIN, gn);
	endtask

	initial begin
		int fed, n, phase, len;
		logic [15:0] nr, fr;

		// Reset defaults: single-sample scan, then every threshold edge
		push_sample(16'd1000, 1'b1);
		push_sample(16'd0, 1'b0);      // first sample forced obstacle
		push_sample(16'd0, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'd500, 1'b0);    // equal to near limit: free
		push_sample(16'd1500, 1'b0);   // equal to far limit: free
		push_sample(16'd501, 1'b0);
		push_sample(16'd1499, 1'b0);
		push_sample(16'd0, 1'b1);      // free value, but last forces obstacle

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		drain();

		// Equal-length runs keep the first; the last sample closes a longer one
		write_all(16'd100, 16'd60000, 16'd0, 16'd1023, 16'd0, 16'hFFFF);
		push_sample(16'd1000, 1'b0);
		push_sample(16'd50, 1'b0);
		push_sample(16'd60000, 1'b0);
		push_sample(16'd1000, 1'b0);
		push_sample(16'd0, 1'b0);
		push_sample(16'd100, 1'b0);
		push_sample(16'd1000, 1'b0);
		push_sample(16'd7, 1'b0);
		push_sample(16'd65000, 1'b0);
		push_sample(16'd9, 1'b0);
		push_sample(16'd1000, 1'b1);
		drain();

		// Long scan with every range value free: one run spans all but the first and last samples
		write_all(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd16384, 16'd40000);
		add_scan(300);
		drain();

		fed = 320;
		phase = 0;
		while (fed < 1850) begin
			case (phase)
				0: write_all(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
				1: write_all(16'hFFFF, 16'hFFFF, 16'd4095, 16'd1023, 16'd32767, 16'hFFFF);
				2: write_all(16'd0, 16'd0, 16'd0, 16'd1023, 16'd0, 16'hFFFF);
				default: begin
					if ($urandom_range(0, 5) == 0) begin
						nr = 16'($urandom);
						fr = 16'($urandom);
					end else begin
						nr = 16'($urandom_range(0, 4000));
						fr = 16'(nr + $urandom_range(0, 6000));
					end
					write_all(nr, fr,
						16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
							: $urandom_range(0, 24)),
						16'($urandom_range(0, 1023)), 16'($urandom_range(0, 32767)),
						16'($urandom));
				end
			endcase
			// no idling at the tail of the run
			idle_en = (fed < 1550) && ($urandom_range(0, 3) != 0);
			n = 0;
			while (n < 150) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 250)
					: $urandom_range(1, 40);
				add_scan(len);
				n += len;
			end
			fed += n;
			phase++;
			drain();
		end

		repeat (20) @(posedge clk);
		if (err_count == 0 && scan_result_q.size() == 0)
			$display("PASS largest_gap_steering_core");
		else
			$display("FAIL largest_gap_steering_core");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL largest_gap_steering_core");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/lgs_pkg.sv
rtl/core/largest_gap_steering_core.sv
verif/testbench.sv
